>>> rtl/rtte_pkg.sv
// Shared types and constants for the RTT estimator / retransmit timer core.
// No dependencies; imported by rtt_estimator_retransmit_timer_core.
package rtte_pkg;

    localparam int EST_W  = 24;   // smoothed rtt and deviation width
    localparam int TO_W   = 18;   // timeout width in whole seconds
    localparam int CMD_W  = 3;
    localparam int SEC_W  = 8;    // min/max timeout register width
    localparam int RETX_W = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [EST_W-1:0] EST_MAX = {EST_W{1'b1}};
    localparam logic [TO_W-1:0]  TO_MAX  = {TO_W{1'b1}};
    localparam logic [RETX_W-1:0] RETX_SAT = {RETX_W{1'b1}};

    typedef enum logic [CMD_W-1:0] {
        CMD_INIT    = 3'd0,
        CMD_NEW_PKT = 3'd1,
        CMD_START   = 3'd2,
        CMD_STOP    = 3'd3,
        CMD_TIMEOUT = 3'd4
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_TIMEOUT = 2'd0,
        CFG_MAX_TIMEOUT = 2'd1,
        CFG_MAX_RETX    = 2'd2
    } t_cfg_idx;

endpackage

>>> rtl/rtt_estimator_retransmit_timer_core.sv
// Retransmit timer core: smoothed RTT / mean deviation estimator with exponential backoff.
// Depends on rtte_pkg for field widths, command codes and register indexes.
//
// Usage:
//   Input stream (s_axis_*): one command word per beat; tuser carries the command
//   (init, new packet, start, response, timeout), tdata the elapsed time in seconds
//   with FRAC_BITS fraction bits. Output stream (m_axis_*): exactly one result word
//   per command word, in order: timeout to arm, give-up flag, srtt and deviation.
//   Config channel (i_cfg_*): register writes, always ready; write only while idle.
//   Pipeline: an accepted word goes into the input register, then the estimator/timer
//   update writes the result register. Throughput: one word per cycle, as long as the
//   output is not stalled by a low m_axis_tready.
//   Stall: when m_axis_tready is low the result word holds, the input register
//   still takes one more word, then s_axis_tready drops until the output drains.
//   Reset (i_rst_n low, synchronous): srtt 0, deviation 1.5 s, timeouts and
//   retransmit count 0, registers back to min 2 s, max 120 s, 4 retransmits;
//   both stream stages empty.
module rtt_estimator_retransmit_timer_core
    import rtte_pkg::*;
#(
    parameter int FRAC_BITS         = 8,
    parameter int MAX_BACKOFF_SHIFT = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [23:0]           s_axis_tdata,   // [23:0] elapsed_time
    input  logic [CMD_W-1:0]      s_axis_tuser,   // [2:0] cmd
    // output stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [17:0] timeout_seconds, [18] give_up, [42:19] smoothed_rtt,
    // [66:43] rtt_deviation, [71:67] zero
    output logic [71:0]           m_axis_tdata,
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SUM_W = EST_W + 2;
    localparam int BO_W  = TO_W + MAX_BACKOFF_SHIFT;
    localparam logic [EST_W-1:0]  DEV_INIT = EST_W'(3 << (FRAC_BITS - 1));
    localparam logic [SUM_W-1:0]  RND_HALF = SUM_W'(1) << (FRAC_BITS - 1);
    localparam logic [RETX_W-1:0] BO_CAP   = RETX_W'(MAX_BACKOFF_SHIFT);

    // configuration registers
    logic [SEC_W-1:0]  r_min_to, r_max_to;
    logic [RETX_W-1:0] r_max_retx;

    // state
    logic [EST_W-1:0]  r_srtt, n_srtt;
    logic [EST_W-1:0]  r_dev, n_dev;
    logic [TO_W-1:0]   r_cur_to, n_cur_to;
    logic [TO_W-1:0]   r_carry_to, n_carry_to;
    logic [RETX_W-1:0] r_retx, n_retx;

    // input register
    logic              r_in_valid;
    logic [CMD_W-1:0]  r_in_cmd;
    logic [EST_W-1:0]  r_in_rtt;

    // result register
    logic              r_out_valid;
    logic [TO_W-1:0]   r_out_to, n_out_to;
    logic              r_out_gu, n_out_gu;
    logic [EST_W-1:0]  r_out_srtt, r_out_dev;

    logic adv;
    assign adv           = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || adv;
    assign o_cfg_ready   = 1'b1;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out_dev, r_out_srtt, r_out_gu, r_out_to};

    // ---------------- start: timeout computation ----------------
    logic [RETX_W-1:0] bo_sh;
    logic [BO_W-1:0]   bo_val;
    logic [TO_W-1:0]   bo_to;
    logic [SUM_W-1:0]  rto_sum, rto_sec;
    logic [SEC_W-1:0]  rto_clamp;

    always_comb begin
        bo_sh  = (r_retx > BO_CAP) ? BO_CAP : r_retx;
        bo_val = {{MAX_BACKOFF_SHIFT{1'b0}}, r_cur_to} << bo_sh;
        bo_to  = (bo_val > BO_W'(TO_MAX)) ? TO_MAX : bo_val[TO_W-1:0];

        rto_sum = {2'b00, r_srtt} + {1'b0, r_dev, 1'b0} + RND_HALF;
        rto_sec = rto_sum >> FRAC_BITS;
        // when they cross, the minimum wins only for a value below it; any other value takes the maximum
        if (rto_sec < SUM_W'(r_min_to)) begin
            rto_clamp = r_min_to;
        end else if (rto_sec > SUM_W'(r_max_to)) begin
            rto_clamp = r_max_to;
        end else begin
            rto_clamp = rto_sec[SEC_W-1:0];
        end
    end

    // ---------------- stop: estimator update ----------------
    logic signed [EST_W:0]   err, err_sh, derr, derr_sh;
    logic        [EST_W-1:0] aerr;
    logic signed [EST_W+1:0] srtt_sum, dev_sum;
    logic        [EST_W-1:0] srtt_upd, dev_upd;

    always_comb begin
        err      = $signed({1'b0, r_in_rtt}) - $signed({1'b0, r_srtt});
        err_sh   = err >>> 3;
        srtt_sum = $signed({2'b00, r_srtt}) + $signed({err_sh[EST_W], err_sh});
        aerr     = err[EST_W] ? EST_W'(-err) : err[EST_W-1:0];
        derr     = $signed({1'b0, aerr}) - $signed({1'b0, r_dev});
        derr_sh  = derr >>> 2;
        dev_sum  = $signed({2'b00, r_dev}) + $signed({derr_sh[EST_W], derr_sh});

        if (srtt_sum[EST_W+1]) begin
            srtt_upd = '0;
        end else if (srtt_sum[EST_W]) begin
            srtt_upd = EST_MAX;
        end else begin
            srtt_upd = srtt_sum[EST_W-1:0];
        end
        if (dev_sum[EST_W+1]) begin
            dev_upd = '0;
        end else if (dev_sum[EST_W]) begin
            dev_upd = EST_MAX;
        end else begin
            dev_upd = dev_sum[EST_W-1:0];
        end
    end

    // ---------------- timeout: retransmit count ----------------
    logic [RETX_W:0] retx_inc, retx_cap, retx_sat;
    always_comb begin
        retx_inc = {1'b0, r_retx} + 1'b1;
        retx_cap = {1'b0, r_max_retx} + 1'b1;
        if (retx_cap > {1'b0, RETX_SAT}) begin
            retx_cap = {1'b0, RETX_SAT};
        end
        retx_sat = (retx_inc > retx_cap) ? retx_cap : retx_inc;
    end

    // ---------------- next state ----------------
    always_comb begin
        n_srtt     = r_srtt;
        n_dev      = r_dev;
        n_cur_to   = r_cur_to;
        n_carry_to = r_carry_to;
        n_retx     = r_retx;
        n_out_to   = '0;
        n_out_gu   = 1'b0;
        case (t_cmd'(r_in_cmd))
            CMD_INIT: begin
                n_srtt     = '0;
                n_dev      = DEV_INIT;
                n_carry_to = '0;
            end
            CMD_NEW_PKT: begin
                n_retx = '0;
            end
            CMD_START: begin
                if (r_retx != '0) begin
                    n_cur_to = bo_to;
                end else if (r_carry_to != '0) begin
                    n_cur_to   = r_carry_to;
                    n_carry_to = '0;
                end else begin
                    n_cur_to = TO_W'(rto_clamp);
                end
                n_out_to = n_cur_to;
            end
            CMD_STOP, CMD_TIMEOUT: begin
                // resent packet: keep estimators, carry the backed-off timeout
                if (r_retx != '0) begin
                    n_carry_to = r_cur_to;
                end else begin
                    n_carry_to = '0;
                    n_srtt     = srtt_upd;
                    n_dev      = dev_upd;
                end
                if (t_cmd'(r_in_cmd) == CMD_TIMEOUT) begin
                    n_out_gu = (retx_inc > {1'b0, r_max_retx});
                    n_retx   = retx_sat[RETX_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_to   <= SEC_W'(2);
            r_max_to   <= SEC_W'(120);
            r_max_retx <= RETX_W'(4);
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_MIN_TIMEOUT: r_min_to   <= i_cfg_data;
                CFG_MAX_TIMEOUT: r_max_to   <= i_cfg_data;
                CFG_MAX_RETX:    r_max_retx <= i_cfg_data[RETX_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_srtt     <= '0;
            r_dev      <= DEV_INIT;
            r_cur_to   <= '0;
            r_carry_to <= '0;
            r_retx     <= '0;
        end else if (adv) begin
            r_srtt     <= n_srtt;
            r_dev      <= n_dev;
            r_cur_to   <= n_cur_to;
            r_carry_to <= n_carry_to;
            r_retx     <= n_retx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_cmd <= s_axis_tuser;
            r_in_rtt <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_to   <= n_out_to;
            r_out_gu   <= n_out_gu;
            r_out_srtt <= n_srtt;
            r_out_dev  <= n_dev;
        end
    end

`ifndef SYNTH
    // a word in the input register stays until it moves to the result register
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !adv |=> r_in_valid)
        else $error("input word dropped while result stage busy");

    // an accepted word always lands in the input register
    a_in_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_in_valid)
        else $error("accepted word not captured");

    // give-up comes only from a timeout command, which arms no timeout
    a_gu_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_gu |-> r_out_to == '0)
        else $error("give-up together with a nonzero timeout");

    // the reported estimators are the live state after the update
    a_est_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> r_out_srtt == r_srtt && r_out_dev == r_dev)
        else $error("result estimators differ from state");
`endif

endmodule
